// ===== rtl/core/fbre_pkg.sv =====
// ----------------------------------------------------------------------------
// fbre_pkg
// Shared constants for the rotating-slot flash EEPROM emulation block:
// default geometry, command codes, result status codes and the erased byte value.
// ----------------------------------------------------------------------------
package fbre_pkg;

    localparam int BLOCK_BYTES_DEF = 64;
    localparam int SLOT_COUNT_DEF  = 32;

    localparam logic       CMD_READ  = 1'b0;
    localparam logic       CMD_WRITE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_WRAP  = 2'd3;

    localparam logic [7:0] ERASED_BYTE = 8'hFF;

endpackage

// ===== rtl/core/flash_block_rotating_eeprom_top.sv =====
// ----------------------------------------------------------------------------
// flash_block_rotating_eeprom_top
// A good read passes S_RD then S_DONE; a range or empty read goes straight to S_DONE.
// A write merges its byte into staging in S_MERGE before S_DONE.
// The first write of a run first copies the live slot into staging in S_LOAD
// (erased bytes if the store is empty); the closing write programs a slot in S_COMMIT.
// One word at a time; a new word is taken while a finished result waits.
// Synchronous active-low reset clears control state; no RAM sweep.
// ----------------------------------------------------------------------------
module flash_block_rotating_eeprom_top #(
    parameter int BLOCK_BYTES = fbre_pkg::BLOCK_BYTES_DEF,
    parameter int SLOT_COUNT  = fbre_pkg::SLOT_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_cmd,
    input  logic [7:0] i_offset,
    input  logic [7:0] i_wr_byte,
    input  logic       i_run_end,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_rd_byte,
    output logic [1:0] o_status,
    output logic [4:0] o_slot_used
);
    import fbre_pkg::*;

    localparam int FD  = SLOT_COUNT * BLOCK_BYTES;
    localparam int FAW = $clog2(FD);
    localparam int BW  = $clog2(FD + 1);
    localparam int SW  = $clog2(BLOCK_BYTES);
    localparam int CW  = $clog2(BLOCK_BYTES + 1);
    localparam int FW  = $clog2(SLOT_COUNT + 1);

    localparam logic [8:0]    BLK_LIM   = 9'(BLOCK_BYTES);
    localparam logic [CW-1:0] BLK_CNT   = CW'(BLOCK_BYTES);
    localparam logic [FW-1:0] FILL_FULL = FW'(SLOT_COUNT);
    localparam logic [BW-1:0] BLK_STEP  = BW'(BLOCK_BYTES);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RD     = 3'd1;
    localparam logic [2:0] S_LOAD   = 3'd2;
    localparam logic [2:0] S_MERGE  = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    // memories
    logic [7:0] r_flash [FD];
    logic [7:0] r_stage [BLOCK_BYTES];
    logic [7:0] r_fl_q;
    logic [7:0] r_st_q;

    // control and payload registers
    logic [2:0]    r_state,     n_state;
    logic [FW-1:0] r_fill,      n_fill;
    logic [BW-1:0] r_live_base, n_live_base;
    logic [BW-1:0] r_next_base, n_next_base;
    logic [BW-1:0] r_tgt_base,  n_tgt_base;
    logic          r_wrap,      n_wrap;
    logic          r_run_open,  n_run_open;
    logic          r_run_bad,   n_run_bad;
    logic [CW-1:0] r_cnt,       n_cnt;
    logic [7:0]    r_off,       n_off;
    logic [7:0]    r_byte,      n_byte;
    logic          r_end,       n_end;
    logic [7:0]    r_res_byte,  n_res_byte;
    logic [1:0]    r_res_status, n_res_status;
    logic [4:0]    r_res_slot,  n_res_slot;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_rd_byte;
    logic [1:0]    r_status;
    logic [4:0]    r_slot_used;

    // memory port controls
    logic          fl_re;
    logic [BW-1:0] fl_raddr;
    logic          fl_we;
    logic [BW-1:0] fl_waddr;
    logic          st_re;
    logic [SW-1:0] st_raddr;
    logic          st_we;
    logic [SW-1:0] st_waddr;
    logic [7:0]    st_wdata;

    logic          load_out;
    logic          in_rng_i;
    logic          in_rng_r;
    logic [FW-1:0] fill_m1;
    logic [CW-1:0] cnt_m1;
    logic [4:0]    live5;

    assign in_rng_i = ({1'b0, i_offset} < BLK_LIM);
    assign in_rng_r = ({1'b0, r_off} < BLK_LIM);
    assign fill_m1  = r_fill - 1'b1;
    assign cnt_m1   = r_cnt - 1'b1;
    assign live5    = (r_fill == '0) ? 5'd0 : 5'(fill_m1);

    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_live_base  = r_live_base;
        n_next_base  = r_next_base;
        n_tgt_base   = r_tgt_base;
        n_wrap       = r_wrap;
        n_run_open   = r_run_open;
        n_run_bad    = r_run_bad;
        n_cnt        = r_cnt;
        n_off        = r_off;
        n_byte       = r_byte;
        n_end        = r_end;
        n_res_byte   = r_res_byte;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        fl_re        = 1'b0;
        fl_raddr     = '0;
        fl_we        = 1'b0;
        fl_waddr     = '0;
        st_re        = 1'b0;
        st_raddr     = '0;
        st_we        = 1'b0;
        st_waddr     = '0;
        st_wdata     = r_byte;
        load_out     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_off        = i_offset;
                    n_byte       = i_wr_byte;
                    n_end        = i_run_end;
                    n_res_byte   = 8'd0;
                    n_res_status = ST_OK;
                    n_res_slot   = live5;
                    if (i_cmd == CMD_READ) begin
                        if (!in_rng_i) begin
                            n_res_status = ST_RANGE;
                            n_state      = S_DONE;
                        end else if (r_fill == '0) begin
                            n_res_status = ST_EMPTY;
                            n_state      = S_DONE;
                        end else begin
                            fl_re    = 1'b1;
                            fl_raddr = r_live_base + BW'(i_offset);
                            n_state  = S_RD;
                        end
                    end else if (!r_run_open) begin
                        n_run_open = 1'b1;
                        n_run_bad  = 1'b0;
                        n_cnt      = '0;
                        n_state    = S_LOAD;
                    end else begin
                        n_state = S_MERGE;
                    end
                end
            end
            S_RD: begin
                n_res_byte = r_fl_q;
                n_state    = S_DONE;
            end
            S_LOAD: begin
                // copy live slot into staging, or fill with erased bytes
                if (r_cnt != BLK_CNT && r_fill != '0) begin
                    fl_re    = 1'b1;
                    fl_raddr = r_live_base + BW'(r_cnt);
                end
                if (r_cnt != '0) begin
                    st_we    = 1'b1;
                    st_waddr = cnt_m1[SW-1:0];
                    st_wdata = (r_fill == '0) ? ERASED_BYTE : r_fl_q;
                end
                if (r_cnt == BLK_CNT) begin
                    n_state = S_MERGE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_MERGE: begin
                if (in_rng_r) begin
                    st_we    = 1'b1;
                    st_waddr = r_off[SW-1:0];
                    st_wdata = r_byte;
                end
                if (!r_end) begin
                    n_res_status = in_rng_r ? ST_OK : ST_RANGE;
                    if (!in_rng_r) begin
                        n_run_bad = 1'b1;
                    end
                    n_state = S_DONE;
                end else begin
                    n_run_open = 1'b0;
                    if (r_run_bad || !in_rng_r) begin
                        n_run_bad    = 1'b0;
                        n_res_status = ST_RANGE;
                        n_state      = S_DONE;
                    end else begin
                        n_wrap     = (r_fill == FILL_FULL);
                        n_tgt_base = (r_fill == FILL_FULL) ? '0 : r_next_base;
                        n_cnt      = '0;
                        n_state    = S_COMMIT;
                    end
                end
            end
            S_COMMIT: begin
                // program staging into the target slot
                if (r_cnt != BLK_CNT) begin
                    st_re    = 1'b1;
                    st_raddr = r_cnt[SW-1:0];
                end
                if (r_cnt != '0) begin
                    fl_we    = 1'b1;
                    fl_waddr = r_tgt_base + BW'(cnt_m1);
                end
                if (r_cnt == BLK_CNT) begin
                    n_fill       = r_wrap ? FW'(1) : r_fill + 1'b1;
                    n_live_base  = r_tgt_base;
                    n_next_base  = r_tgt_base + BLK_STEP;
                    n_res_status = r_wrap ? ST_WRAP : ST_OK;
                    n_res_slot   = r_wrap ? 5'd0 : 5'(r_fill);
                    n_state      = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fl_we) begin
            r_flash[fl_waddr[FAW-1:0]] <= r_st_q;
        end
        if (fl_re) begin
            r_fl_q <= r_flash[fl_raddr[FAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_stage[st_waddr] <= st_wdata;
        end
        if (st_re) begin
            r_st_q <= r_stage[st_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_live_base <= '0;
            r_next_base <= '0;
            r_run_open  <= 1'b0;
            r_run_bad   <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_live_base <= n_live_base;
            r_next_base <= n_next_base;
            r_run_open  <= n_run_open;
            r_run_bad   <= n_run_bad;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tgt_base   <= n_tgt_base;
        r_wrap       <= n_wrap;
        r_off        <= n_off;
        r_byte       <= n_byte;
        r_end        <= n_end;
        r_res_byte   <= n_res_byte;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        if (load_out) begin
            r_rd_byte   <= r_res_byte;
            r_status    <= r_res_status;
            r_slot_used <= r_res_slot;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_rd_byte   = r_rd_byte;
    assign o_status    = r_status;
    assign o_slot_used = r_slot_used;

endmodule

// ===== rtl/core/fbre_checker.sv =====
// ----------------------------------------------------------------------------
// fbre_checker
// Port-level checks for the rotating-slot flash EEPROM block, bound to the
// top level.
// ----------------------------------------------------------------------------
module fbre_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       i_cmd,
    input logic [7:0] i_offset,
    input logic [7:0] i_wr_byte,
    input logic       i_run_end,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_rd_byte,
    input logic [1:0] o_status,
    input logic [4:0] o_slot_used
);
    import fbre_pkg::*;

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_rd_byte)
            && $stable(o_status) && $stable(o_slot_used))
        else $error("result word changed while stalled");

    // one word in flight: stall rises right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("accepted a word while busy");

    // only a good read carries data
    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rd_byte != 8'd0 |-> o_status == ST_OK)
        else $error("data returned with bad status");

    // empty store reports slot zero and no data
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_EMPTY |-> o_slot_used == 5'd0 && o_rd_byte == 8'd0)
        else $error("empty status with slot or data");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("not idle after reset");

endmodule

bind flash_block_rotating_eeprom_top fbre_checker u_fbre_checker (.*);

// ===== tb/tb_flash_block_rotating_eeprom_top.sv =====
// ----------------------------------------------------------------------------
// tb_flash_block_rotating_eeprom_top
// Self-checking bench for the rotating-slot flash EEPROM emulation block.
// A behavioral copy of the slot ring, marks and staging image predicts every
// result word; a checker process compares each returned word field by field.
// Directed cases cover the empty store, range errors, discarded runs and
// reads inside an open run. Random write runs and reads follow, which wrap
// the store several times, under random idling and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_flash_block_rotating_eeprom_top;
    import fbre_pkg::*;

    localparam int BYTES       = BLOCK_BYTES_DEF;
    localparam int SLOTS       = SLOT_COUNT_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 2 * BYTES + 16;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [7:0] rd_byte;
        logic [1:0] status;
        logic [4:0] slot;
    } t_eep_result;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       cmd = CMD_READ;
    logic [7:0] offset = 8'h00;
    logic [7:0] wr_byte = 8'h00;
    logic       run_end = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] rd_byte;
    logic [1:0] status;
    logic [4:0] slot_used;

    // behavioral image of the store
    logic [7:0] flash_img [SLOTS*BYTES];
    bit         slot_mark [SLOTS];
    logic [7:0] stage_img [BYTES];
    bit         run_open = 1'b0;
    bit         run_bad = 1'b0;

    t_eep_result pending_results [$];

    bit          gaps_on = 1'b1;
    bit          hold_toggle = 1'b0;
    bit          hold_seen = 1'b0;
    int unsigned hold_left = 0;
    int unsigned cycle_cnt = 0;
    int unsigned n_errors = 0;
    int unsigned n_reads = 0;
    int unsigned n_writes = 0;
    int unsigned n_commits = 0;
    int unsigned n_dropped = 0;
    int unsigned n_wraps = 0;
    int unsigned n_checked = 0;

    flash_block_rotating_eeprom_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_cmd       (cmd),
        .i_offset    (offset),
        .i_wr_byte   (wr_byte),
        .i_run_end   (run_end),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_rd_byte   (rd_byte),
        .o_status    (status),
        .o_slot_used (slot_used)
    );

    initial forever #2 clk = ~clk;

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        n_errors++;
        if (n_errors <= 50) begin
            $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        end
    endtask

    task automatic eeprom_predict(input logic c, input logic [7:0] off,
                                  input logic [7:0] data, input logic last);
        t_eep_result r;
        int unsigned nfree;
        bit          in_range;
        nfree = 0;
        while (nfree < SLOTS && slot_mark[nfree]) nfree++;
        in_range  = off < BYTES;
        r.rd_byte = 8'h00;
        r.status  = ST_OK;
        r.slot    = (nfree == 0) ? 5'd0 : 5'(nfree - 1);
        if (c == CMD_READ) begin
            n_reads++;
            if (!in_range) begin
                r.status = ST_RANGE;
            end else if (nfree == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.rd_byte = flash_img[(nfree - 1) * BYTES + off];
            end
        end else begin
            n_writes++;
            if (!run_open) begin
                for (int i = 0; i < BYTES; i++) begin
                    stage_img[i] = (nfree == 0) ? ERASED_BYTE
                                                : flash_img[(nfree - 1) * BYTES + i];
                end
                run_open = 1'b1;
                run_bad  = 1'b0;
            end
            if (in_range) stage_img[off] = data;
            else run_bad = 1'b1;
            if (!last) begin
                if (!in_range) r.status = ST_RANGE;
            end else begin
                run_open = 1'b0;
                if (run_bad) begin
                    run_bad  = 1'b0;
                    r.status = ST_RANGE;
                    n_dropped++;
                end else begin
                    if (nfree >= SLOTS) begin
                        foreach (flash_img[i]) flash_img[i] = ERASED_BYTE;
                        foreach (slot_mark[i]) slot_mark[i] = 1'b0;
                        nfree    = 0;
                        r.status = ST_WRAP;
                        n_wraps++;
                    end
                    for (int i = 0; i < BYTES; i++) flash_img[nfree * BYTES + i] = stage_img[i];
                    slot_mark[nfree] = 1'b1;
                    r.slot = 5'(nfree);
                    n_commits++;
                end
            end
        end
        pending_results.push_back(r);
    endtask

    // offer one word, wait for it to be taken, then record its expected result
    task automatic send_word(input logic c, input logic [7:0] off,
                             input logic [7:0] data, input logic last);
        if (gaps_on && $urandom_range(0, 99) < 10) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        offset   <= off;
        wr_byte  <= data;
        run_end  <= last;
        do @(posedge clk); while (in_stall);
        eeprom_predict(c, off, data, last);
    endtask

    function automatic logic [7:0] rand_offset();
        if ($urandom_range(0, 15) == 0) return 8'($urandom_range(BYTES, 255));
        return 8'($urandom_range(0, BYTES - 1));
    endfunction

    always @(posedge clk) begin : result_check
        t_eep_result want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                n_checked++;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result word, status", status, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (rd_byte !== want.rd_byte)
                        report_mismatch("rd_byte", rd_byte, want.rd_byte);
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                    if (slot_used !== want.slot)
                        report_mismatch("slot_used", slot_used, want.slot);
                end
            end
            if (hold_toggle != hold_seen) begin
                hold_seen = hold_toggle;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= gaps_on && ($urandom_range(0, 99) < 10);
            end
        end
    end

    task automatic test_empty_store();
        send_word(CMD_READ, 8'd0, 8'h00, 1'b0);
        send_word(CMD_READ, 8'(BYTES - 1), 8'hFF, 1'b1);
        send_word(CMD_READ, 8'(BYTES), 8'h00, 1'b0);
        send_word(CMD_READ, 8'd255, 8'h00, 1'b0);
    endtask

    task automatic test_first_commit();
        send_word(CMD_WRITE, 8'd0, 8'h00, 1'b0);
        send_word(CMD_WRITE, 8'(BYTES - 1), 8'hFF, 1'b0);
        send_word(CMD_WRITE, 8'd7, 8'hA5, 1'b1);
        send_word(CMD_READ, 8'd0, 8'h00, 1'b0);
        send_word(CMD_READ, 8'(BYTES - 1), 8'h00, 1'b0);
        send_word(CMD_READ, 8'd7, 8'h00, 1'b0);
        send_word(CMD_READ, 8'd1, 8'h00, 1'b0);
    endtask

    task automatic test_bad_run();
        send_word(CMD_WRITE, 8'd10, 8'h55, 1'b0);
        send_word(CMD_WRITE, 8'(BYTES), 8'h11, 1'b0);
        send_word(CMD_WRITE, 8'd3, 8'h22, 1'b1);
        send_word(CMD_WRITE, 8'd255, 8'hFF, 1'b1);
        send_word(CMD_READ, 8'd10, 8'h00, 1'b0);
    endtask

    task automatic test_read_in_run();
        send_word(CMD_WRITE, 8'd20, 8'h5A, 1'b0);
        send_word(CMD_READ, 8'd20, 8'h00, 1'b0);
        send_word(CMD_WRITE, 8'd21, 8'hC3, 1'b1);
        send_word(CMD_READ, 8'd20, 8'h00, 1'b0);
    endtask

    // write runs with random content and reads, a few runs broken by bad offsets
    task automatic random_traffic(input int unsigned n_items);
        int unsigned sent;
        int unsigned len;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 55) begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_word(CMD_READ, rand_offset(), 8'($urandom), 1'($urandom));
                        sent++;
                    end
                    send_word(CMD_WRITE, rand_offset(), 8'($urandom), k == len - 1);
                    sent++;
                end
            end else begin
                send_word(CMD_READ, rand_offset(), 8'($urandom), 1'($urandom));
                sent++;
            end
        end
    endtask

    task automatic test_backpressure();
        gaps_on     <= 1'b0;
        hold_toggle <= ~hold_toggle;
        for (int k = 0; k < 12; k++) begin
            send_word(CMD_READ, rand_offset(), 8'($urandom), 1'b0);
        end
        send_word(CMD_WRITE, 8'd1, 8'($urandom), 1'b0);
        send_word(CMD_WRITE, 8'd2, 8'($urandom), 1'b1);
        send_word(CMD_READ, 8'd2, 8'h00, 1'b0);
        gaps_on <= 1'b1;
    endtask

    initial begin
        foreach (flash_img[i]) flash_img[i] = ERASED_BYTE;
        foreach (slot_mark[i]) slot_mark[i] = 1'b0;
        foreach (stage_img[i]) stage_img[i] = 8'h00;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_store();
        test_first_commit();
        test_bad_run();
        test_read_in_run();
        random_traffic(300);
        gaps_on <= 1'b0;
        random_traffic(300);
        gaps_on <= 1'b1;
        test_backpressure();
        random_traffic(450);

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results still outstanding", pending_results.size(), 0);

        $display("covered %0d reads, %0d write words, %0d commits, %0d discarded runs",
                 n_reads, n_writes, n_commits, n_dropped);
        $display("store wrapped %0d times, %0d result words checked", n_wraps, n_checked);
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/fbre_pkg.sv
rtl/core/flash_block_rotating_eeprom_top.sv
rtl/core/fbre_checker.sv
tb/tb_flash_block_rotating_eeprom_top.sv
